// ===== hdl/qpd_pkg.sv =====
// Shared types, constants and the transition table of the quadrature position decoder.
package qpd_pkg;

  // Direction codes, as reported on the result channel.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  // Configuration register indexes (byte address bits [4:2]).
  localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [2:0] REG_ACCEL_EN  = 3'd1;
  localparam logic [2:0] REG_ACCEL_THR = 3'd2;
  localparam logic [2:0] REG_LIMIT_EN  = 3'd3;
  localparam logic [2:0] REG_MIN_LIMIT = 3'd4;
  localparam logic [2:0] REG_MAX_LIMIT = 3'd5;

  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;

  // Field widths of the registers.
  localparam int unsigned DEBOUNCE_BITS = 16;
  localparam int unsigned THR_BITS      = 12;
  localparam int unsigned LIMIT_BITS    = 32;
  localparam int unsigned STAMP_BITS    = 32;
  localparam int unsigned POS_OUT_BITS  = 32;

  // Default sizes of the position counter and the time stamps.
  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned TIME_BITS_DEF     = 32;

  // Reset values of the registers.
  localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RST = 16'd2;
  localparam logic [THR_BITS-1:0]      THR_RST      = 12'd60;

  // Speed is SPEED_NUM / elapsed; thresholds are turned into elapsed-time bounds.
  localparam int unsigned SPEED_NUM  = 3000;
  localparam int unsigned SPEED_FAST = 200;
  localparam int unsigned SPEED_MID  = 120;
  localparam int unsigned EL_FAST_MAX = SPEED_NUM / (SPEED_FAST + 1);
  localparam int unsigned EL_MID_MAX  = SPEED_NUM / (SPEED_MID + 1);
  localparam int unsigned EL_BITS     = 12;
  localparam int unsigned PROD_BITS   = THR_BITS + 1 + EL_BITS;

  // Step sizes.
  localparam logic [3:0] STEP_1 = 4'd1;
  localparam logic [3:0] STEP_2 = 4'd2;
  localparam logic [3:0] STEP_4 = 4'd4;
  localparam logic [3:0] STEP_8 = 4'd8;

  // Gray-code transition table indexed by previous and current {clk, dt}.
  function automatic dir_t trans_dir(input logic [1:0] prev, input logic [1:0] cur);
    dir_t d;
    case ({prev, cur})
      4'b0001: d = DIR_CCW;
      4'b0010: d = DIR_CW;
      4'b0100: d = DIR_CW;
      4'b0111: d = DIR_CCW;
      4'b1000: d = DIR_CCW;
      4'b1011: d = DIR_CW;
      4'b1101: d = DIR_CW;
      4'b1110: d = DIR_CCW;
      default: d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/quadrature_position_decoder_core.sv =====
// Quadrature position decoder: sample decode, debounce, acceleration, position count and clamp.
//
// The input channel carries one sample per beat: the two encoder line levels and a
// millisecond time stamp. The result channel returns one beat per sample: the position
// after the sample, the last direction and a flag for a counted step.
// A sample is first captured in an input register. Combinational logic then decodes the
// Gray-code transition, checks the debounce time, picks the step size from elapsed time
// and updates and clamps the position; the result lands in the output register.
// Throughput is one sample per cycle unless the receiver stalls; the limit is the single
// compute stage, whose state update (position, stamps, pins) feeds the next sample directly.
// When the receiver stalls, the held result stays put and the input register can still
// take one more sample; further input is stalled until the output frees up.
// Configuration goes through the APB-style port at byte address 4*index; writes apply
// at the access cycle and pready is always high. Writing accel_enable as 0 resets the
// step size to one.
// Reset (rst_n low, synchronous) restores register defaults, clears both pipeline
// registers and sets pins to both high, position to zero and direction to none.
module quadrature_position_decoder_core #(
  parameter int unsigned POSITION_BITS = qpd_pkg::POSITION_BITS_DEF,
  parameter int unsigned TIME_BITS     = qpd_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_clk_level,
  input  logic                                in_dt_level,
  input  logic [qpd_pkg::STAMP_BITS-1:0]      in_now_time,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qpd_pkg::POS_OUT_BITS-1:0] out_position_out,
  output logic [1:0]                          out_direction_out,
  output logic                                out_moved,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qpd_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [qpd_pkg::DATA_BITS-1:0]       pwdata,
  output logic [qpd_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);

  localparam int unsigned CW = (POSITION_BITS > qpd_pkg::LIMIT_BITS) ?
                               POSITION_BITS : qpd_pkg::LIMIT_BITS;

  // Configuration registers.
  logic [qpd_pkg::DEBOUNCE_BITS-1:0]       debounce_r;
  logic                                    accel_en_r;
  logic [qpd_pkg::THR_BITS-1:0]            thr_r;
  logic                                    limit_en_r;
  logic signed [qpd_pkg::LIMIT_BITS-1:0]   min_limit_r;
  logic signed [qpd_pkg::LIMIT_BITS-1:0]   max_limit_r;

  // Decoder state.
  logic [1:0]                              prev_pins_r;
  logic [POSITION_BITS-1:0]                position_r;
  qpd_pkg::dir_t                           last_dir_r;
  logic [3:0]                              step_size_r;
  logic [TIME_BITS-1:0]                    last_step_time_r;
  logic [TIME_BITS-1:0]                    last_rot_r;

  // Input register.
  logic                                    s1_vld_r;
  logic                                    s1_clk_r;
  logic                                    s1_dt_r;
  logic [TIME_BITS-1:0]                    s1_now_r;

  // Output register.
  logic                                    out_vld_r;
  logic signed [qpd_pkg::POS_OUT_BITS-1:0] pos_out_r;
  logic [1:0]                              dir_out_r;
  logic                                    moved_r;

  // Handshake and compute signals.
  logic                                    cfg_wr;
  logic                                    in_accept;
  logic                                    out_free;
  logic                                    fire;
  logic [1:0]                              pins;
  logic [TIME_BITS-1:0]                    el_step;
  logic [TIME_BITS-1:0]                    el_rot;
  logic                                    pass;
  qpd_pkg::dir_t                           dir;
  logic                                    count;
  logic [qpd_pkg::THR_BITS:0]              thr_p1;
  logic [qpd_pkg::PROD_BITS-1:0]           prod;
  logic                                    in_range;
  logic                                    above_thr;
  logic [3:0]                              step_new;
  logic [3:0]                              step_use;
  logic [POSITION_BITS-1:0]                pos_step;
  logic signed [CW-1:0]                    pos_wide;
  logic signed [CW-1:0]                    lo_wide;
  logic signed [CW-1:0]                    hi_wide;
  logic [POSITION_BITS-1:0]                pos_clamp;
  logic [1:0]                              prev_pins_nxt;
  logic [POSITION_BITS-1:0]                position_nxt;
  qpd_pkg::dir_t                           last_dir_nxt;
  logic [3:0]                              step_size_nxt;
  logic [TIME_BITS-1:0]                    last_step_time_nxt;
  logic [TIME_BITS-1:0]                    last_rot_nxt;
  logic signed [CW-1:0]                    out_wide;

  // Channel control.
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign out_free  = !out_vld_r || !out_stall;
  assign fire      = s1_vld_r && out_free;
  assign in_stall  = s1_vld_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign pready    = 1'b1;

  assign out_valid         = out_vld_r;
  assign out_position_out  = pos_out_r;
  assign out_direction_out = dir_out_r;
  assign out_moved         = moved_r;

  // Register read-back.
  always_comb begin
    case (paddr[qpd_pkg::ADDR_BITS-1:2])
      qpd_pkg::REG_DEBOUNCE:  prdata = qpd_pkg::DATA_BITS'(debounce_r);
      qpd_pkg::REG_ACCEL_EN:  prdata = qpd_pkg::DATA_BITS'(accel_en_r);
      qpd_pkg::REG_ACCEL_THR: prdata = qpd_pkg::DATA_BITS'(thr_r);
      qpd_pkg::REG_LIMIT_EN:  prdata = qpd_pkg::DATA_BITS'(limit_en_r);
      qpd_pkg::REG_MIN_LIMIT: prdata = qpd_pkg::DATA_BITS'(min_limit_r);
      qpd_pkg::REG_MAX_LIMIT: prdata = qpd_pkg::DATA_BITS'(max_limit_r);
      default:                prdata = '0;
    endcase
  end

  // Debounce gate and transition decode.
  assign pins    = {s1_clk_r, s1_dt_r};
  assign el_step = s1_now_r - last_step_time_r;
  assign el_rot  = s1_now_r - last_rot_r;
  assign pass    = (el_step >= TIME_BITS'(debounce_r)) && (pins != prev_pins_r);
  assign dir     = qpd_pkg::trans_dir(prev_pins_r, pins);
  assign count   = pass && (dir != qpd_pkg::DIR_NONE);

  // Speed above threshold means (threshold + 1) * elapsed <= SPEED_NUM.
  assign in_range  = el_rot <= TIME_BITS'(qpd_pkg::SPEED_NUM);
  assign thr_p1    = {1'b0, thr_r} + (qpd_pkg::THR_BITS+1)'(1);
  assign prod      = qpd_pkg::PROD_BITS'(thr_p1) *
                     qpd_pkg::PROD_BITS'(el_rot[qpd_pkg::EL_BITS-1:0]);
  assign above_thr = in_range && (prod <= qpd_pkg::PROD_BITS'(qpd_pkg::SPEED_NUM));

  // Step size selection; zero elapsed time keeps the previous size.
  always_comb begin
    step_new = step_size_r;
    if (el_rot != '0) begin
      if (above_thr) begin
        if (el_rot <= TIME_BITS'(qpd_pkg::EL_FAST_MAX)) begin
          step_new = qpd_pkg::STEP_8;
        end else if (el_rot <= TIME_BITS'(qpd_pkg::EL_MID_MAX)) begin
          step_new = qpd_pkg::STEP_4;
        end else begin
          step_new = qpd_pkg::STEP_2;
        end
      end else begin
        step_new = qpd_pkg::STEP_1;
      end
    end
  end

  assign step_use = accel_en_r ? step_new : qpd_pkg::STEP_1;

  // Position update with wrap, then optional clamp (below-minimum test wins).
  assign pos_step = (dir == qpd_pkg::DIR_CW) ? position_r + POSITION_BITS'(step_use)
                                             : position_r - POSITION_BITS'(step_use);
  assign pos_wide = CW'($signed(pos_step));
  assign lo_wide  = CW'(min_limit_r);
  assign hi_wide  = CW'(max_limit_r);

  always_comb begin
    pos_clamp = pos_step;
    if (limit_en_r) begin
      if (pos_wide < lo_wide) begin
        pos_clamp = lo_wide[POSITION_BITS-1:0];
      end else if (hi_wide < pos_wide) begin
        pos_clamp = hi_wide[POSITION_BITS-1:0];
      end
    end
  end

  // Next state for one sample.
  always_comb begin
    prev_pins_nxt      = prev_pins_r;
    position_nxt       = position_r;
    last_dir_nxt       = last_dir_r;
    step_size_nxt      = step_size_r;
    last_step_time_nxt = last_step_time_r;
    last_rot_nxt       = last_rot_r;
    if (pass) begin
      prev_pins_nxt = pins;
    end
    if (count) begin
      position_nxt       = pos_clamp;
      last_dir_nxt       = dir;
      last_step_time_nxt = s1_now_r;
      last_rot_nxt       = s1_now_r;
      if (accel_en_r) begin
        step_size_nxt = step_new;
      end
    end
  end

  assign out_wide = CW'($signed(position_nxt));

  // Configuration registers and decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r       <= qpd_pkg::DEBOUNCE_RST;
      accel_en_r       <= 1'b0;
      thr_r            <= qpd_pkg::THR_RST;
      limit_en_r       <= 1'b0;
      min_limit_r      <= '0;
      max_limit_r      <= '0;
      prev_pins_r      <= 2'b11;
      position_r       <= '0;
      last_dir_r       <= qpd_pkg::DIR_NONE;
      step_size_r      <= qpd_pkg::STEP_1;
      last_step_time_r <= '0;
      last_rot_r       <= '0;
    end else begin
      if (fire) begin
        prev_pins_r      <= prev_pins_nxt;
        position_r       <= position_nxt;
        last_dir_r       <= last_dir_nxt;
        last_step_time_r <= last_step_time_nxt;
        last_rot_r       <= last_rot_nxt;
      end
      // Turning acceleration off drops the step size back to one.
      if (cfg_wr && (paddr[qpd_pkg::ADDR_BITS-1:2] == qpd_pkg::REG_ACCEL_EN) && !pwdata[0]) begin
        step_size_r <= qpd_pkg::STEP_1;
      end else if (fire) begin
        step_size_r <= step_size_nxt;
      end
      if (cfg_wr) begin
        case (paddr[qpd_pkg::ADDR_BITS-1:2])
          qpd_pkg::REG_DEBOUNCE:  debounce_r  <= pwdata[qpd_pkg::DEBOUNCE_BITS-1:0];
          qpd_pkg::REG_ACCEL_EN:  accel_en_r  <= pwdata[0];
          qpd_pkg::REG_ACCEL_THR: thr_r       <= pwdata[qpd_pkg::THR_BITS-1:0];
          qpd_pkg::REG_LIMIT_EN:  limit_en_r  <= pwdata[0];
          qpd_pkg::REG_MIN_LIMIT: min_limit_r <= $signed(pwdata[qpd_pkg::LIMIT_BITS-1:0]);
          qpd_pkg::REG_MAX_LIMIT: max_limit_r <= $signed(pwdata[qpd_pkg::LIMIT_BITS-1:0]);
          default: ;
        endcase
      end
    end
  end

  // Input register: takes a beat whenever it is empty or draining this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_accept) begin
      s1_vld_r <= 1'b1;
    end else if (fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_clk_r <= in_clk_level;
      s1_dt_r  <= in_dt_level;
      s1_now_r <= TIME_BITS'(in_now_time);
    end
  end

  // Output register: loads the result beat, holds it while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos_out_r <= out_wide[qpd_pkg::POS_OUT_BITS-1:0];
      dir_out_r <= 2'(last_dir_nxt);
      moved_r   <= count;
    end
  end

  // A counted step always reports a direction.
  a_moved_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_moved) |-> (out_direction_out != 2'(qpd_pkg::DIR_NONE)))
    else $error("result beat with a counted step carries no direction");

  // The step size is always one of 1, 2, 4 or 8.
  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(step_size_r))
    else $error("step size is not a power of two");

  // Without acceleration the step size stays at one.
  a_step_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !accel_en_r |-> (step_size_r == qpd_pkg::STEP_1))
    else $error("step size differs from one with acceleration off");

  // Input stalls only when the input register holds a beat that cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked beat");

  // A sample that counts a step records its time stamp.
  a_stamp_update: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && count) |=> (last_step_time_r == $past(s1_now_r)))
    else $error("step time not recorded for a counted step");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the quadrature position decoder core.
`timescale 1ns / 100ps

module tb_top;

  // Cycles with no beat on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Extra cycles allowed after the last result.
  localparam int unsigned DRAIN_CYCLES   = 8;
  // Address beyond the last register, used to check that such writes are ignored.
  localparam logic [2:0]  REG_UNUSED     = 3'd6;

  // Speed scale and step-size thresholds, in revolutions per minute.
  localparam int unsigned RPM_SCALE = 3000;
  localparam int unsigned RPM_FAST  = 200;
  localparam int unsigned RPM_MID   = 120;

  localparam logic [3:0] STRIDE_1 = 4'd1;
  localparam logic [3:0] STRIDE_2 = 4'd2;
  localparam logic [3:0] STRIDE_4 = 4'd4;
  localparam logic [3:0] STRIDE_8 = 4'd8;

  // Distances on the Gray cycle that mean a valid turn.
  localparam logic [1:0] GRAY_BACK = 2'd3;
  localparam logic [1:0] GRAY_FWD  = 2'd1;

  typedef struct packed {
    logic signed [31:0] position;
    qpd_pkg::dir_t      direction;
    logic               moved;
  } qpd_result_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        in_clk_level = 1'b1;
  logic        in_dt_level  = 1'b1;
  logic [31:0] in_now_time  = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic signed [31:0] out_position_out;
  logic [1:0]  out_direction_out;
  logic        out_moved;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [qpd_pkg::ADDR_BITS-1:0] paddr  = '0;
  logic [qpd_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [qpd_pkg::DATA_BITS-1:0] prdata;
  logic        pready;

  quadrature_position_decoder_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_clk_level     (in_clk_level),
    .in_dt_level      (in_dt_level),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position_out (out_position_out),
    .out_direction_out(out_direction_out),
    .out_moved        (out_moved),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Shadow copy of the decoder registers.
  logic [15:0]        cfg_debounce = 16'd2;
  logic               cfg_accel    = 1'b0;
  logic [11:0]        cfg_thr      = 12'd60;
  logic               cfg_limit    = 1'b0;
  logic signed [31:0] cfg_min      = '0;
  logic signed [31:0] cfg_max      = '0;

  // Shadow copy of the decoder state, as after reset.
  logic [1:0]         seen_pins      = 2'b11;
  logic signed [31:0] position_acc   = '0;
  qpd_pkg::dir_t      heading        = qpd_pkg::DIR_NONE;
  logic [3:0]         stride         = STRIDE_1;
  logic [31:0]        step_stamp     = '0;
  logic [31:0]        rotation_stamp = '0;

  qpd_result_t expected_results[$];
  qpd_result_t oldest_expected;

  int errors        = 0;
  int samples_sent  = 0;
  int results_seen  = 0;
  int steps_counted = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;
  int idle_pct      = 0;
  int stall_pct     = 0;

  logic [31:0] walk_time = '0;
  bit          walk_cw   = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Map between pin pairs and positions on the Gray cycle; the mapping is its own inverse.
  function automatic logic [1:0] gray_swap(input logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  // Pin pair one valid step away from the last stored pins.
  function automatic logic [1:0] step_pins(input bit cw);
    logic [1:0] g;
    g = gray_swap(seen_pins);
    g = cw ? g - 2'd1 : g + 2'd1;
    return gray_swap(g);
  endfunction

  // Advance the shadow state by one sample and return the result it must produce.
  function automatic qpd_result_t predict_sample(input logic [1:0] pins, input logic [31:0] now);
    qpd_result_t        res;
    logic [1:0]         turn;
    qpd_pkg::dir_t      dir;
    logic [31:0]        since_step;
    logic [31:0]        elapsed;
    logic [31:0]        speed;
    logic [31:0]        amount;
    logic signed [31:0] next_pos;
    res.moved  = 1'b0;
    since_step = now - step_stamp;
    if (since_step >= {16'd0, cfg_debounce} && pins != seen_pins) begin
      turn = gray_swap(pins) - gray_swap(seen_pins);
      dir  = qpd_pkg::DIR_NONE;
      if (turn == GRAY_BACK) dir = qpd_pkg::DIR_CW;
      else if (turn == GRAY_FWD) dir = qpd_pkg::DIR_CCW;
      if (dir != qpd_pkg::DIR_NONE) begin
        amount = 32'd1;
        if (cfg_accel) begin
          // Zero elapsed time keeps the stride of the previous step.
          elapsed = now - rotation_stamp;
          if (elapsed != 32'd0) begin
            speed = 32'(RPM_SCALE) / elapsed;
            if (speed > {20'd0, cfg_thr}) begin
              if (speed > 32'(RPM_FAST)) stride = STRIDE_8;
              else if (speed > 32'(RPM_MID)) stride = STRIDE_4;
              else stride = STRIDE_2;
            end else begin
              stride = STRIDE_1;
            end
          end
          amount = {28'd0, stride};
        end
        next_pos = (dir == qpd_pkg::DIR_CW) ? position_acc + amount : position_acc - amount;
        // The lower bound is tested first, so it wins when min is above max.
        if (cfg_limit) begin
          if (next_pos < cfg_min) next_pos = cfg_min;
          else if (next_pos > cfg_max) next_pos = cfg_max;
        end
        position_acc   = next_pos;
        heading        = dir;
        rotation_stamp = now;
        step_stamp     = now;
        res.moved      = 1'b1;
      end
      seen_pins = pins;
    end
    res.position  = position_acc;
    res.direction = heading;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Send one sample beat, idling the sender for random cycles first, and record its result.
  task automatic send_sample(input logic [1:0] pins, input logic [31:0] now);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_clk_level <= pins[1];
    in_dt_level  <= pins[0];
    in_now_time  <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_sample(pins, now));
    samples_sent++;
  endtask

  // Stop sending and wait until every result is back and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      qpd_pkg::REG_DEBOUNCE: cfg_debounce = value[15:0];
      qpd_pkg::REG_ACCEL_EN: begin
        cfg_accel = value[0];
        if (!value[0]) stride = STRIDE_1;
      end
      qpd_pkg::REG_ACCEL_THR: cfg_thr = value[11:0];
      qpd_pkg::REG_LIMIT_EN: cfg_limit = value[0];
      qpd_pkg::REG_MIN_LIMIT: cfg_min = value;
      qpd_pkg::REG_MAX_LIMIT: cfg_max = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_settings(input logic [15:0] debounce, input logic accel,
                                input logic [11:0] thr, input logic limit,
                                input logic [31:0] lo, input logic [31:0] hi);
    wait_idle();
    write_reg(qpd_pkg::REG_DEBOUNCE, {16'd0, debounce});
    write_reg(qpd_pkg::REG_ACCEL_EN, {31'd0, accel});
    write_reg(qpd_pkg::REG_ACCEL_THR, {20'd0, thr});
    write_reg(qpd_pkg::REG_LIMIT_EN, {31'd0, limit});
    write_reg(qpd_pkg::REG_MIN_LIMIT, lo);
    write_reg(qpd_pkg::REG_MAX_LIMIT, hi);
  endtask

  // Reset defaults: debounce, unchanged pins, invalid jump, both turns, time wrap.
  task automatic test_reset_state();
    idle_pct  = 0;
    stall_pct = 0;
    send_sample(2'b11, 32'd0);
    send_sample(2'b01, 32'd10);
    send_sample(2'b00, 32'd11);
    send_sample(2'b00, 32'd12);
    send_sample(2'b00, 32'd20);
    send_sample(2'b11, 32'd30);
    send_sample(2'b10, 32'd40);
    send_sample(2'b00, 32'd42);
    send_sample(2'b01, 32'd44);
    send_sample(2'b11, 32'hFFFF_FFFF);
    send_sample(2'b01, 32'd0);
    send_sample(2'b01, 32'd1);
    send_sample(2'b00, 32'd1);
  endtask

  // Stride selection by speed, zero elapsed time, disable, and threshold extremes.
  task automatic test_acceleration();
    apply_settings(16'd0, 1'b1, 12'd60, 1'b0, 32'd0, 32'd0);
    send_sample(step_pins(1'b1), 32'd11);
    send_sample(step_pins(1'b1), 32'd11);
    send_sample(step_pins(1'b1), 32'd31);
    send_sample(step_pins(1'b1), 32'd56);
    send_sample(step_pins(1'b1), 32'd156);
    wait_idle();
    write_reg(qpd_pkg::REG_ACCEL_EN, 32'd0);
    write_reg(qpd_pkg::REG_ACCEL_EN, 32'd1);
    send_sample(step_pins(1'b1), 32'd156);
    wait_idle();
    write_reg(qpd_pkg::REG_ACCEL_THR, 32'd3000);
    send_sample(step_pins(1'b1), 32'd157);
    wait_idle();
    write_reg(qpd_pkg::REG_ACCEL_THR, 32'd0);
    send_sample(step_pins(1'b1), 32'd3157);
    send_sample(step_pins(1'b0), 32'd3167);
  endtask

  // Clamping at the extremes, wrap of the position, min above max, ignored address.
  task automatic test_limits_and_wrap();
    apply_settings(16'd0, 1'b0, 12'd60, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(step_pins(1'b1), 32'd4000);
    wait_idle();
    write_reg(qpd_pkg::REG_LIMIT_EN, 32'd0);
    send_sample(step_pins(1'b1), 32'd4001);
    wait_idle();
    write_reg(qpd_pkg::REG_LIMIT_EN, 32'd1);
    write_reg(qpd_pkg::REG_MIN_LIMIT, 32'd100);
    write_reg(qpd_pkg::REG_MAX_LIMIT, -32'sd100);
    send_sample(step_pins(1'b0), 32'd4002);
    send_sample(step_pins(1'b1), 32'd4003);
    wait_idle();
    write_reg(qpd_pkg::REG_MIN_LIMIT, 32'h8000_0000);
    write_reg(qpd_pkg::REG_MAX_LIMIT, 32'h7FFF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(step_pins(1'b0), 32'd4004);
    send_sample(seen_pins, 32'd4005);
  endtask

  // Mostly valid Gray walks with random timing, plus repeats, invalid jumps and noise.
  task automatic test_random_walk(input int count, input int idle_p, input int stall_p);
    int          n;
    int          pick;
    logic [31:0] delta;
    logic [1:0]  pins;
    idle_pct  = idle_p;
    stall_pct = stall_p;
    walk_time = step_stamp;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) delta = $urandom_range(0, 30);
      else if (pick < 75) delta = {16'd0, cfg_debounce} + $urandom_range(0, 40) - 32'd1;
      else if (pick < 92) delta = $urandom_range(0, 4000);
      else delta = $urandom();
      walk_time = walk_time + delta;
      if ($urandom_range(0, 99) < 3) walk_time = $urandom();
      if ($urandom_range(0, 99) < 10) walk_cw = !walk_cw;
      pick = $urandom_range(0, 99);
      if (pick < 78) pins = step_pins(walk_cw);
      else if (pick < 88) pins = seen_pins;
      else if (pick < 95) pins = ~seen_pins;
      else pins = 2'($urandom());
      send_sample(pins, walk_time);
    end
  endtask

  // Receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with no sample outstanding");
      end else begin
        oldest_expected = expected_results.pop_front();
        if (oldest_expected.moved) steps_counted++;
        if (out_position_out !== oldest_expected.position)
          report_mismatch($sformatf("position %0d, expected %0d",
                                    out_position_out, oldest_expected.position));
        if (out_direction_out !== oldest_expected.direction)
          report_mismatch($sformatf("direction %0d, expected %0d",
                                    out_direction_out, oldest_expected.direction));
        if (out_moved !== oldest_expected.moved)
          report_mismatch($sformatf("moved %0b, expected %0b",
                                    out_moved, oldest_expected.moved));
      end
    end
  end

  // Watchdog: end the run when no beat moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_acceleration();
    test_limits_and_wrap();

    apply_settings(16'd0, 1'b1, 12'd60, 1'b0, 32'd0, 32'd0);
    test_random_walk(435, 0, 0);
    apply_settings(16'd2, 1'b1, 12'($urandom_range(0, 250)), 1'b1, -32'sd200, 32'sd200);
    test_random_walk(435, 47, 0);
    apply_settings(16'hFFFF, 1'b0, 12'd3000, 1'b1, 32'sd40, -32'sd40);
    test_random_walk(435, 0, 47);
    apply_settings(16'($urandom_range(0, 8)), 1'b1, 12'd0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    test_random_walk(435, 25, 25);

    wait_idle();
    $display("Covered %0d samples and %0d result beats, %0d of them counted steps,",
             samples_sent, results_seen, steps_counted);
    $display("with %0d register writes over four idle and stall phases; %0d mismatches.",
             cfg_writes, errors);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
